>>> rtl/core/lph_pkg.sv
`default_nettype none

package lph_pkg;

    localparam int LPH_CAPACITY = 1024;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 2;
    localparam int RES_W  = 2;
    localparam int IDX_W  = 10;
    localparam int LIM_W  = 11;
    localparam int VCNT_W = 11;
    localparam int SLST_W = 2;

    localparam logic [LIM_W-1:0] FILL_LIMIT_RST = 11'd819;

    // home slot remainder: key bits taken DIGIT_W per cycle, msb first
    localparam int DIGIT_W    = 4;
    localparam int HASH_STEPS = KEY_W / DIGIT_W;
    localparam int HSTEP_W    = $clog2(HASH_STEPS + 1);

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [RES_W-1:0] {
        RES_OK        = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_DUP       = 2'd2,
        RES_FULL      = 2'd3
    } t_res;

    typedef enum logic [SLST_W-1:0] {
        SL_EMPTY   = 2'd0,
        SL_VALID   = 2'd1,
        SL_DELETED = 2'd2
    } t_slot;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic hash_step;
        logic seed;
        logic advance;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic hash_done;
        logic probe_end;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/lph_ctrl.sv
`default_nettype none

module lph_ctrl import lph_pkg::*; #(
    parameter int CAPACITY = LPH_CAPACITY
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_PROBE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (POW2) begin
                        // home slot is the low key bits, read it right away
                        o_cmd.seed = 1'b1;
                        n_state    = S_PROBE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_PROBE;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_PROBE: begin
                if (i_stat.probe_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_hash_to_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH && i_stat.hash_done) |=> (r_state == S_PROBE))
        else $error("hash done did not start the probe");

endmodule

`default_nettype wire

>>> rtl/core/lph_dp.sv
`default_nettype none

module lph_dp import lph_pkg::*; #(
    parameter int CAPACITY = LPH_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [CMD_W-1:0]   i_op,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_cfg_valid,
    input  logic [LIM_W-1:0]   i_cfg_data,
    output logic               o_done,
    output logic [RES_W-1:0]   o_status,
    output logic [VAL_W-1:0]   o_found_value,
    output logic [IDX_W-1:0]   o_slot_index
);

    localparam int  AW   = $clog2(CAPACITY);
    localparam int  MW   = SLST_W + KEY_W + VAL_W;
    localparam int  EW   = (AW > IDX_W) ? AW : IDX_W;
    localparam bit  POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    // slot memory: {status, key, value}
    logic [MW-1:0] r_mem [CAPACITY];
    logic [MW-1:0] r_rdata;

    logic [AW-1:0]      r_clr;
    logic [CMD_W-1:0]   r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic [KEY_W-1:0]   r_kbuf;
    logic [AW-1:0]      r_rem;
    logic [HSTEP_W-1:0] r_hcnt;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_cnt;
    logic [AW-1:0]      r_free;
    logic               r_free_vld;
    logic [VCNT_W-1:0]  r_vcnt;
    logic [LIM_W-1:0]   r_limit;
    logic               r_done;
    logic [RES_W-1:0]   r_status;
    logic [VAL_W-1:0]   r_fval;
    logic [IDX_W-1:0]   r_idx;

    logic [AW:0]        h_acc;
    logic [AW-1:0]      n_rem;
    logic [AW-1:0]      home;
    logic [AW-1:0]      next_ptr;
    logic [AW-1:0]      rd_addr;

    t_slot              rd_st;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic               is_valid;
    logic               hit;
    logic               free_now_vld;
    logic [AW-1:0]      free_now;

    t_res               fin_res;
    logic [VAL_W-1:0]   fin_fval;
    logic [AW-1:0]      fin_slot;
    logic               fin_we;
    logic [AW-1:0]      fin_waddr;
    logic [MW-1:0]      fin_wdata;
    logic               fin_inc;
    logic               fin_dec;
    logic [EW-1:0]      slot_ext;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [MW-1:0]      mem_wdata;

    // remainder step: rem stays below CAPACITY, so one subtract per bit
    always_comb begin
        h_acc = {1'b0, r_rem};
        for (int b = 0; b < DIGIT_W; b++) begin
            h_acc = {h_acc[AW-1:0], r_kbuf[KEY_W-1-b]};
            if (h_acc >= (AW+1)'(CAPACITY)) begin
                h_acc = h_acc - (AW+1)'(CAPACITY);
            end
        end
        n_rem = h_acc[AW-1:0];
    end

    assign home     = POW2 ? i_key[AW-1:0] : r_rem;
    assign next_ptr = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;

    always_comb begin
        priority if (i_cmd.seed) begin
            rd_addr = home;
        end else if (i_cmd.advance) begin
            rd_addr = next_ptr;
        end else begin
            rd_addr = r_ptr;
        end
    end

    // r_rdata always holds the slot at r_ptr while probing
    assign rd_st    = t_slot'(r_rdata[MW-1 -: SLST_W]);
    assign rd_key   = r_rdata[KEY_W+VAL_W-1 -: KEY_W];
    assign rd_val   = r_rdata[VAL_W-1:0];
    assign is_valid = (rd_st == SL_VALID);
    assign hit      = is_valid && (rd_key == r_key);

    assign free_now_vld = r_free_vld || !is_valid;
    assign free_now     = r_free_vld ? r_free : r_ptr;

    assign o_stat.clear_last = (r_clr == LAST);
    assign o_stat.hash_done  = (r_hcnt == HSTEP_W'(HASH_STEPS));
    assign o_stat.probe_end  = (rd_st == SL_EMPTY) || hit || (r_cnt == LAST);

    always_comb begin
        fin_res   = RES_NOT_FOUND;
        fin_fval  = '0;
        fin_slot  = '0;
        fin_we    = 1'b0;
        fin_waddr = r_ptr;
        fin_wdata = {SL_DELETED, rd_key, rd_val};
        fin_inc   = 1'b0;
        fin_dec   = 1'b0;
        unique case (r_op)
            OP_INSERT: begin
                // duplicate check wins over full
                if (hit) begin
                    fin_res = RES_DUP;
                end else if (r_vcnt >= r_limit || !free_now_vld) begin
                    fin_res = RES_FULL;
                end else begin
                    fin_res   = RES_OK;
                    fin_slot  = free_now;
                    fin_we    = 1'b1;
                    fin_waddr = free_now;
                    fin_wdata = {SL_VALID, r_key, r_value};
                    fin_inc   = 1'b1;
                end
            end
            OP_FIND: begin
                if (hit) begin
                    fin_res  = RES_OK;
                    fin_fval = rd_val;
                    fin_slot = r_ptr;
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    fin_res  = RES_OK;
                    fin_slot = r_ptr;
                    fin_we   = 1'b1;
                    fin_dec  = (r_vcnt != '0);
                end
            end
            default: begin
                fin_res = RES_NOT_FOUND;
            end
        endcase
    end

    assign slot_ext = EW'(fin_slot);

    assign mem_we    = i_cmd.clear_wr || (i_cmd.finish && fin_we);
    assign mem_waddr = i_cmd.clear_wr ? r_clr : fin_waddr;
    assign mem_wdata = i_cmd.clear_wr ? '0 : fin_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_vcnt  <= '0;
            r_limit <= FILL_LIMIT_RST;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.finish && fin_inc) begin
                r_vcnt <= r_vcnt + 1'b1;
            end else if (i_cmd.finish && fin_dec) begin
                r_vcnt <= r_vcnt - 1'b1;
            end
            r_done <= i_cmd.finish;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_key  <= i_key;
            r_value <= i_value;
            r_kbuf <= i_key;
            r_rem  <= '0;
            r_hcnt <= '0;
        end else if (i_cmd.hash_step) begin
            r_kbuf <= r_kbuf << DIGIT_W;
            r_rem  <= n_rem;
            r_hcnt <= r_hcnt + 1'b1;
        end
        if (i_cmd.seed) begin
            r_ptr      <= home;
            r_cnt      <= '0;
            r_free_vld <= 1'b0;
        end else if (i_cmd.advance) begin
            r_ptr <= next_ptr;
            r_cnt <= r_cnt + 1'b1;
            if (!r_free_vld && !is_valid) begin
                r_free     <= r_ptr;
                r_free_vld <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_status <= fin_res;
            r_fval   <= fin_fval;
            r_idx    <= slot_ext[IDX_W-1:0];
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = r_fval;
    assign o_slot_index  = r_idx;

    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_vcnt) <= CAPACITY)
        else $error("valid count above capacity");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == RES_OK && r_op == OP_INSERT)
        |-> (r_vcnt == VCNT_W'($past(r_vcnt) + 1'b1)))
        else $error("insert did not raise the valid count");

    a_fval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(r_status == RES_OK && r_op == OP_FIND)) |-> (r_fval == '0))
        else $error("found value set without a find hit");

endmodule

`default_nettype wire

>>> rtl/core/linear_probe_hash_table_unit.sv
`default_nettype none

// channel   | signals                                   | direction | handshake
// ----------+-------------------------------------------+-----------+--------------------------
// command   | start, i_cmd, i_key, i_value              | in        | start && !busy
// result    | o_done, o_status, o_found_value, o_slot_index | out   | o_done, one cycle
// config    | i_cfg_valid, i_cfg_data, o_cfg_ready      | in        | i_cfg_valid && o_cfg_ready
//
// After reset the slot memory is cleared one slot a cycle, with busy high.
// An item probes its slots, one memory read per cycle, before the next item is accepted; a capacity
// that is not a power of two first works out the home slot remainder, 4 key bits a cycle.
// The result strobe comes in the cycle after the last probe; busy is low in that cycle.
// The result cannot be held off; fill_limit writes are always taken.

module linear_probe_hash_table_unit import lph_pkg::*; #(
    parameter int CAPACITY = LPH_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VAL_W-1:0]   i_value,
    output logic               o_done,
    output logic [RES_W-1:0]   o_status,
    output logic [VAL_W-1:0]   o_found_value,
    output logic [IDX_W-1:0]   o_slot_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIM_W-1:0]   i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lph_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    lph_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_op          (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_slot_index  (o_slot_index)
    );

    assign o_cfg_ready = 1'b1;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

endmodule

`default_nettype wire
